// File: design/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
`default_nettype none
package owbm_pkg;

  localparam int TICK_W    = 10;
  localparam int CFG_COUNT = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [TICK_W-1:0] tick_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_RESET = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_REST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_GAP     = 3'd7;

  localparam tick_t CFG_DEFAULTS [CFG_COUNT] = '{
    10'd480, 10'd60, 10'd420, 10'd1, 10'd60, 10'd15, 10'd45, 10'd1
  };

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage
`default_nettype wire

// File: design/one_wire_bus_master.sv
// One-wire bus master: tick-driven sequencer for bus reset, byte write and byte read.
// The result of a tick appears in the output register in the cycle after its transfer.
// Throughput: one tick per cycle; a stalled result holds off the next tick.
// The sequencer state and result register update together on each transferred tick.
// Reset (synchronous, active low) idles the sequencer, clears its presence flag and read byte,
// empties the output register and loads the default timing registers.
`default_nettype none
module one_wire_bus_master (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       in_mode,
  input  wire  [7:0]                       in_write_byte,
  input  wire                              in_line_in,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_drive_low,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic                             out_presence_seen,
  output logic [7:0]                       out_read_byte,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [owbm_pkg::TICK_W-1:0]      cfg_data
);
  import owbm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_RECOVER,
    PH_SLOT_START, PH_SLOT_BODY, PH_SLOT_TAIL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  mode_t       op_r, op_nxt;
  tick_t       tick_r, tick_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        presence_r, presence_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  tick_t       cfg_regs_r [CFG_COUNT];

  logic        out_valid_r;
  logic        out_drive_low_r, out_busy_res_r, out_done_res_r, out_presence_seen_r;
  logic [7:0]  out_read_byte_r;

  logic        in_xfer;
  logic        drive, done;
  tick_t       len_raw, len_eff, cnt;
  logic [3:0]  bits_dec;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    tick_nxt      = tick_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    presence_nxt  = presence_r;
    last_read_nxt = last_read_r;
    drive         = 1'b0;
    done          = 1'b0;
    len_raw       = tick_t'(1);
    bits_dec      = bits_r;

    if (phase_r == PH_IDLE && in_mode != MODE_TICK) begin
      op_nxt   = mode_t'(in_mode);
      tick_nxt = '0;
      if (in_mode == MODE_RESET) begin
        phase_nxt = PH_RST_LOW;
        bits_nxt  = '0;
      end else begin
        phase_nxt = PH_SLOT_START;
        bits_nxt  = BITS_PER_BYTE;
        shift_nxt = (in_mode == MODE_WRITE) ? in_write_byte : 8'h00;
      end
    end

    unique case (phase_nxt)
      PH_RST_LOW:     len_raw = cfg_regs_r[REG_RESET_LOW];
      PH_RST_WAIT:    len_raw = cfg_regs_r[REG_PRESENCE];
      PH_RST_RECOVER: len_raw = cfg_regs_r[REG_RECOVERY];
      PH_SLOT_START:  len_raw = cfg_regs_r[REG_SLOT_START];
      PH_SLOT_BODY:   len_raw = (op_nxt == MODE_WRITE) ? cfg_regs_r[REG_WRITE_HOLD]
                                                       : cfg_regs_r[REG_READ_SAMPLE];
      PH_SLOT_TAIL:   len_raw = (op_nxt == MODE_WRITE) ? cfg_regs_r[REG_SLOT_GAP]
                                                       : cfg_regs_r[REG_READ_REST];
      default:        len_raw = tick_t'(1);
    endcase
    len_eff = (len_raw == '0) ? tick_t'(1) : len_raw;
    cnt     = tick_nxt + tick_t'(1);

    if (phase_nxt != PH_IDLE) begin
      unique case (phase_nxt)
        PH_RST_LOW, PH_SLOT_START: drive = 1'b1;
        PH_SLOT_BODY:              drive = (op_nxt == MODE_WRITE) && !shift_nxt[0];
        default:                   drive = 1'b0;
      endcase

      if (cnt >= len_eff) begin
        tick_nxt = '0;
        unique case (phase_nxt)
          PH_RST_LOW: phase_nxt = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence_nxt = !in_line_in;
            phase_nxt    = PH_RST_RECOVER;
          end
          PH_RST_RECOVER: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_SLOT_START: phase_nxt = PH_SLOT_BODY;
          PH_SLOT_BODY: begin
            if (op_nxt == MODE_READ) begin
              shift_nxt = {in_line_in, shift_nxt[7:1]};
            end
            phase_nxt = PH_SLOT_TAIL;
          end
          PH_SLOT_TAIL: begin
            if (op_nxt == MODE_WRITE) begin
              shift_nxt = {1'b0, shift_nxt[7:1]};
            end
            bits_dec = (bits_nxt != '0) ? bits_nxt - 4'd1 : bits_nxt;
            bits_nxt = bits_dec;
            if (bits_dec == '0) begin
              if (op_nxt == MODE_READ) begin
                last_read_nxt = shift_nxt;
              end
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_SLOT_START;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end else begin
        tick_nxt = cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      op_r        <= MODE_TICK;
      tick_r      <= '0;
      bits_r      <= '0;
      shift_r     <= '0;
      presence_r  <= 1'b0;
      last_read_r <= '0;
      out_valid_r <= 1'b0;
      cfg_regs_r  <= CFG_DEFAULTS;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_regs_r[cfg_index] <= cfg_data;
      end
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        op_r        <= op_nxt;
        tick_r      <= tick_nxt;
        bits_r      <= bits_nxt;
        shift_r     <= shift_nxt;
        presence_r  <= presence_nxt;
        last_read_r <= last_read_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_drive_low_r     <= drive;
      out_busy_res_r      <= (phase_nxt != PH_IDLE);
      out_done_res_r      <= done;
      out_presence_seen_r <= presence_nxt;
      out_read_byte_r     <= last_read_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_low     = out_drive_low_r;
  assign out_busy_res      = out_busy_res_r;
  assign out_done_res      = out_done_res_r;
  assign out_presence_seen = out_presence_seen_r;
  assign out_read_byte     = out_read_byte_r;

endmodule
`default_nettype wire

// File: design/owbm_checker.sv
// Port-level assertions for the one-wire bus master and their bind.
`default_nettype none
module owbm_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_stall,
  input wire [1:0]                      in_mode,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire                            out_busy_res,
  input wire                            out_done_res,
  input wire [7:0]                      out_read_byte,
  input wire                            cfg_ready
);
  import owbm_pkg::*;

  // A completed operation never reports busy on the same tick.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_busy_res))
    else $error("done and busy asserted together");

  // An empty output register never holds off the input side.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A tick starting a bus reset while idle yields a busy result.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == MODE_RESET && out_valid && !out_busy_res)
    |=> out_busy_res)
    else $error("reset start from idle did not report busy");

  // A stalled result holds its read byte.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && cfg_ready) |=> (out_valid && $stable(out_read_byte)))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_byte (out_read_byte),
  .cfg_ready     (cfg_ready)
);
`default_nettype wire
